>>> hdl/tmbb_pkg.sv
// Package for the tone map box blur frame store.
// Types, constants and state codes; no dependencies.
`timescale 1ns / 1ps
package tmbb_pkg;
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_RADIUS_DEF = 7;
  localparam int COLOUR_MAX_DEF = 255;

  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] REG_GRAY   = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADD_RD, ST_ADD_WAIT, ST_ADD_WR, ST_WIN, ST_RD, ST_RD_WAIT,
    ST_MUL, ST_DIV, ST_ACC, ST_FDIV, ST_DONE, ST_CLR
  } state_t;
endpackage

>>> hdl/tone_map_box_blur_frame_store_top.sv
// Top level of the tone map box blur frame store.
// Uses tmbb_pkg; holds the frame store memory and the shared divider sequencer.
`timescale 1ns / 1ps
// channel   direction  signals
// command   in         start, kind, pos_x, pos_y, radiance_red/green/blue (busy is out)
// result    out        done, colour_red, colour_green, colour_blue
// config    in         cfg_we, cfg_index, cfg_data
// Busy after the accepting edge: set runs the write state, add the read, wait and write states.
// Read: for N window pixels (1..225), per pixel a memory read and wait, then for each
// of 3 channels a load, a divide and an accumulate in one shared restoring divider;
// then 3 divisions for the final average and a done state to finish.
// Reset starts a clearing pass: busy while all 65536 store words are zeroed.
// done is high for one cycle with the colour, right after busy falls; the receiver cannot stall.
module tone_map_box_blur_frame_store_top #(
  parameter int MAX_WIDTH  = tmbb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tmbb_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = tmbb_pkg::MAX_RADIUS_DEF,
  parameter int COLOUR_MAX = tmbb_pkg::COLOUR_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic [31:0] radiance_red,
  input  logic [31:0] radiance_green,
  input  logic [31:0] radiance_blue,
  output logic        done,
  output logic [7:0]  colour_red,
  output logic [7:0]  colour_green,
  output logic [7:0]  colour_blue,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tmbb_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW = XW + 1;
  localparam int RC = MAX_RADIUS < 7 ? MAX_RADIUS : 7;
  localparam int AW = XW + YW;
  localparam int DEPTH = 2 ** AW;
  localparam int KW = $clog2(COLOUR_MAX + 1);
  localparam int NW = 32 + KW + 8;        // numerator width
  localparam int QW = KW + 8;             // tone result Q8.8
  localparam int NCW = 2 * ($clog2(2 * RC + 2)) + 8;
  localparam int SW = QW + 2 * ($clog2(2 * RC + 2));
  localparam int DW = 33;
  localparam int DVW = NW;

  logic [31:0] middle_gray;
  logic [2:0]  window_radius;
  logic [8:0]  image_width, image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      middle_gray <= 32'd655360;
      window_radius <= '0;
      image_width <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAY:   middle_gray <= cfg_data;
        REG_RADIUS: window_radius <= cfg_data[2:0];
        REG_WIDTH:  image_width <= cfg_data[8:0];
        REG_HEIGHT: image_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // memory
  logic [95:0] mem [DEPTH];
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [95:0] mem_wd, mem_rd;
  logic [AW-1:0] clr_addr;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd <= mem[mem_ra];
  end

  state_t state, state_next;
  logic [1:0]  op;
  logic [XW-1:0] px, x0, x1, cx;
  logic [YW-1:0] py, y0, y1, cy;
  logic [95:0] rad_in, pix;
  logic [1:0]  ch;
  logic [SW-1:0] sum [3];
  logic [NCW-1:0] cnt;
  logic [7:0]  col [3];

  // shared restoring divider
  logic [DVW-1:0] dv_q;
  logic [DW:0]    dv_r;
  logic [DW-1:0]  dv_d;
  logic [6:0]     dv_n;
  logic [DW:0]    dv_t;
  assign dv_t = {dv_r[DW-1:0], dv_q[DVW-1]} - {1'b0, dv_d};

  logic [32:0] den;
  logic [31:0] chv;
  logic [NW-1:0] num;
  always_comb begin
    unique case (ch)
      2'd0: chv = pix[31:0];
      2'd1: chv = pix[63:32];
      default: chv = pix[95:64];
    endcase
  end
  assign den = {1'b0, middle_gray} + {1'b0, chv};

  logic [31:0] sa_r, sa_g, sa_b;
  function automatic logic [31:0] sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
  assign sa_r = sat(mem_rd[31:0], rad_in[31:0]);
  assign sa_g = sat(mem_rd[63:32], rad_in[63:32]);
  assign sa_b = sat(mem_rd[95:64], rad_in[95:64]);

  logic [XW:0] wl;
  logic [YW:0] hl;
  logic [3:0]  rl;
  always_comb begin
    wl = (image_width == 0) ? (XW+1)'(1) : ((image_width > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH)
         : (XW+1)'(image_width));
    hl = (image_height == 0) ? (YW+1)'(1) : ((image_height > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT)
         : (YW+1)'(image_height));
    rl = (window_radius > RC) ? 4'(RC) : 4'(window_radius);
  end

  assign busy = (state != ST_IDLE);
  assign mem_wa = (state == ST_CLR) ? clr_addr : {py, px};
  assign mem_wd = (state == ST_CLR) ? '0 : (op == KIND_ADD) ? {sa_b, sa_g, sa_r} : rad_in;
  assign mem_we = (state == ST_ADD_WR) || (state == ST_CLR);
  assign mem_ra = (state == ST_IDLE) ? {pos_y[YW-1:0], pos_x[XW-1:0]} :
                  (state == ST_ADD_RD || state == ST_ADD_WAIT) ? {py, px} : {cy, cx};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:
        if (start) begin
          if (kind == KIND_SET || kind == KIND_ADD) begin
            if (32'(pos_x) < MAX_WIDTH && 32'(pos_y) < MAX_HEIGHT)
              state_next = (kind == KIND_SET) ? ST_ADD_WR : ST_ADD_RD;
          end else if (kind == KIND_READ) state_next = ST_WIN;
        end
      ST_ADD_RD:   state_next = ST_ADD_WAIT;
      ST_ADD_WAIT: state_next = ST_ADD_WR;
      ST_ADD_WR:   state_next = ST_IDLE;
      ST_WIN:      state_next = ST_RD;
      ST_RD:       state_next = ST_RD_WAIT;
      ST_RD_WAIT:  state_next = ST_MUL;
      ST_MUL:      state_next = ST_DIV;
      ST_DIV:      if (dv_n == 0) state_next = ST_ACC;
      ST_ACC:
        if (ch != 2) state_next = ST_MUL;
        else if (cx == x1 && cy == y1) state_next = ST_FDIV;
        else state_next = ST_RD;
      ST_FDIV:     if (dv_n == 0 && ch == 2) state_next = ST_DONE;
      ST_DONE:     state_next = ST_IDLE;
      ST_CLR:      if (clr_addr == '1) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (state == ST_DONE);
  end

  logic [XW:0] ccx, tx;
  logic [YW:0] ccy, ty;
  always_comb begin
    ccx = ({1'b0, px} > wl - 1'b1) ? wl - 1'b1 : {1'b0, px};
    ccy = ({1'b0, py} > hl - 1'b1) ? hl - 1'b1 : {1'b0, py};
    tx = ccx + (XW+1)'(rl);
    ty = ccy + (YW+1)'(rl);
  end
  assign num = NW'(COLOUR_MAX) * NW'(chv) << 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
      dv_n <= '0;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          op <= kind;
          px <= pos_x[XW-1:0];
          py <= pos_y[YW-1:0];
          rad_in <= {radiance_blue, radiance_green, radiance_red};
        end
        ST_CLR: clr_addr <= clr_addr + 1'b1;
        ST_WIN: begin
          x0 <= (ccx > (XW+1)'(rl)) ? XW'(ccx - (XW+1)'(rl)) : '0;
          y0 <= (ccy > (YW+1)'(rl)) ? YW'(ccy - (YW+1)'(rl)) : '0;
          cx <= (ccx > (XW+1)'(rl)) ? XW'(ccx - (XW+1)'(rl)) : '0;
          cy <= (ccy > (YW+1)'(rl)) ? YW'(ccy - (YW+1)'(rl)) : '0;
          x1 <= (tx > wl - 1) ? XW'(wl - 1) : XW'(tx);
          y1 <= (ty > hl - 1) ? YW'(hl - 1) : YW'(ty);
          for (int i = 0; i < 3; i++) sum[i] <= '0;
          cnt <= '0;
          ch <= '0;
        end
        ST_RD_WAIT: pix <= mem_rd;
        ST_MUL: begin
          dv_q <= (den == 0) ? '0 : num;
          dv_d <= (den == 0) ? DW'(1) : den;
          dv_r <= '0;
          dv_n <= 7'(DVW);
        end
        ST_DIV: if (dv_n != 0) begin
          dv_r <= dv_t[DW] ? {dv_r[DW-1:0], dv_q[DVW-1]} : dv_t;
          dv_q <= {dv_q[DVW-2:0], ~dv_t[DW]};
          dv_n <= dv_n - 1'b1;
        end
        ST_ACC: begin
          sum[ch] <= sum[ch] + SW'(dv_q[QW-1:0]);
          if (ch == 2) begin
            ch <= '0;
            cnt <= cnt + 1'b1;
            if (cx == x1) begin
              cx <= x0;
              cy <= cy + 1'b1;
            end else cx <= cx + 1'b1;
            if (cx == x1 && cy == y1) begin
              dv_q <= DVW'(sum[0]);
              dv_d <= DW'({cnt + 1'b1, 8'd0});
              dv_r <= '0;
              dv_n <= 7'(DVW);
            end
          end else ch <= ch + 1'b1;
        end
        ST_FDIV: begin
          if (dv_n != 0) begin
            dv_r <= dv_t[DW] ? {dv_r[DW-1:0], dv_q[DVW-1]} : dv_t;
            dv_q <= {dv_q[DVW-2:0], ~dv_t[DW]};
            dv_n <= dv_n - 1'b1;
          end else begin
            col[ch] <= (dv_q > 255) ? 8'd255 : dv_q[7:0];
            if (ch == 2) ch <= '0;
            else ch <= ch + 1'b1;
            dv_q <= (ch == 0) ? DVW'(sum[1]) : DVW'(sum[2]);
            dv_r <= '0;
            dv_n <= 7'(DVW);
          end
        end
        ST_DONE: ch <= '0;
        default: ;
      endcase
    end
  end

  assign colour_red = col[0];
  assign colour_green = col[1];
  assign colour_blue = col[2];

  a_busy_on_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_READ |=> busy) else $error("read not taken");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    ch != 2'd3) else $error("channel index out of range");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
endmodule

>>> tb/sv/tb_tone_map_box_blur_frame_store_top.sv
// Testbench for tone_map_box_blur_frame_store_top: directed table, then random phases
// of configuration, image fill and mixed set/add/read traffic checked by a predictor.
// Depends on tmbb_pkg and the top level only.
`timescale 1ns / 1ps
module tb_tone_map_box_blur_frame_store_top;
  import tmbb_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int STORE_W = 256;
  localparam int ITEMS = 1850;
  localparam int QUIET_FROM = 1650;
  localparam longint LIMIT = 40000000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  typedef struct packed {
    bit         is_cfg;
    logic [1:0] code;
    logic [7:0] x;
    logic [7:0] y;
    logic [31:0] rr;
    logic [31:0] rg;
    logic [31:0] rb;
    bit         typed;
    colour_t    col;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start, busy, done, cfg_we;
  logic [1:0] kind, cfg_index;
  logic [7:0] pos_x, pos_y, colour_red, colour_green, colour_blue;
  logic [31:0] radiance_red, radiance_green, radiance_blue, cfg_data;

  tone_map_box_blur_frame_store_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .pos_x(pos_x), .pos_y(pos_y), .radiance_red(radiance_red),
    .radiance_green(radiance_green), .radiance_blue(radiance_blue),
    .done(done), .colour_red(colour_red), .colour_green(colour_green),
    .colour_blue(colour_blue), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mirror of the frame store and registers
  logic [31:0] red_px[STORE_W*STORE_W];
  logic [31:0] green_px[STORE_W*STORE_W];
  logic [31:0] blue_px[STORE_W*STORE_W];
  bit          px_valid[STORE_W*STORE_W];
  logic [31:0] gray_q = 32'd655360;
  logic [2:0]  radius_q = 3'd0;
  logic [8:0]  width_q = 9'd256;
  logic [8:0]  height_q = 9'd256;

  colour_t colour_q[$];
  int  n_sent = 0;
  int  n_acc = 0;
  int  n_items = 0;
  int  errors = 0;
  bit  gaps = 1'b1;
  bit  ovr_on = 1'b0;
  colour_t ovr_col;
  longint cycles = 0;

  function automatic int eff_dim(logic [8:0] v);
    if (v == 0) return 1;
    return (v > STORE_W) ? STORE_W : int'(v);
  endfunction

  function automatic longint unsigned tone_q88(logic [31:0] r);
    longint unsigned den;
    den = longint'(gray_q) + longint'(r);
    if (den == 0) return 0;
    return (longint'(COLOUR_MAX_DEF) * longint'(r) * 256) / den;
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic colour_t window_colour(logic [7:0] px, logic [7:0] py);
    int w, h, cx, cy, x0, y0, x1, y1, idx;
    longint unsigned sr, sg, sb, cnt;
    colour_t c;
    w = eff_dim(width_q);
    h = eff_dim(height_q);
    cx = (px > w - 1) ? w - 1 : int'(px);
    cy = (py > h - 1) ? h - 1 : int'(py);
    x0 = (cx > radius_q) ? cx - int'(radius_q) : 0;
    y0 = (cy > radius_q) ? cy - int'(radius_q) : 0;
    x1 = (cx + int'(radius_q) > w - 1) ? w - 1 : cx + int'(radius_q);
    y1 = (cy + int'(radius_q) > h - 1) ? h - 1 : cy + int'(radius_q);
    sr = 0; sg = 0; sb = 0;
    for (int y = y0; y <= y1; y++) begin
      for (int x = x0; x <= x1; x++) begin
        idx = y * STORE_W + x;
        sr += tone_q88(red_px[idx]);
        sg += tone_q88(green_px[idx]);
        sb += tone_q88(blue_px[idx]);
      end
    end
    cnt = longint'(x1 - x0 + 1) * longint'(y1 - y0 + 1) * 256;
    c.red = (sr / cnt > 255) ? 8'd255 : 8'(sr / cnt);
    c.green = (sg / cnt > 255) ? 8'd255 : 8'(sg / cnt);
    c.blue = (sb / cnt > 255) ? 8'd255 : 8'(sb / cnt);
    return c;
  endfunction

  // transfer monitor: update mirror, queue colours, check results
  always @(posedge clk) begin
    colour_t got, want;
    int idx;
    if (!rst) begin
      if (done) begin
        got = '{colour_red, colour_green, colour_blue};
        if (colour_q.size() == 0) begin
          $error("unexpected result %h", got);
          errors++;
        end else begin
          want = colour_q.pop_front();
          if (got.red !== want.red) begin
            $error("colour_red exp %0d got %0d", want.red, got.red);
            errors++;
          end
          if (got.green !== want.green) begin
            $error("colour_green exp %0d got %0d", want.green, got.green);
            errors++;
          end
          if (got.blue !== want.blue) begin
            $error("colour_blue exp %0d got %0d", want.blue, got.blue);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        n_acc <= n_acc + 1;
        idx = int'(pos_y) * STORE_W + int'(pos_x);
        if (kind == KIND_SET || kind == KIND_ADD) begin
          if (kind == KIND_ADD && px_valid[idx]) begin
            red_px[idx] = sat_sum(red_px[idx], radiance_red);
            green_px[idx] = sat_sum(green_px[idx], radiance_green);
            blue_px[idx] = sat_sum(blue_px[idx], radiance_blue);
          end else begin
            red_px[idx] = radiance_red;
            green_px[idx] = radiance_green;
            blue_px[idx] = radiance_blue;
          end
          px_valid[idx] = 1'b1;
        end else if (kind == KIND_READ) begin
          colour_q.insert(colour_q.size(), ovr_on ? ovr_col : window_colour(pos_x, pos_y));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic issue(logic [1:0] k, logic [7:0] x, logic [7:0] y,
                       logic [31:0] r, logic [31:0] g, logic [31:0] b);
    if (gaps && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 14)) @(posedge clk);
    @(posedge clk);
    start <= 1'b1;
    kind <= k;
    pos_x <= x;
    pos_y <= y;
    radiance_red <= r;
    radiance_green <= g;
    radiance_blue <= b;
    n_sent++;
    if (k != KIND_NONE) n_items++;
    wait (n_acc == n_sent);
    start <= 1'b0;
  endtask

  task automatic settle();
    wait (colour_q.size() == 0);
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gaps) repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_GRAY:   gray_q = val;
      REG_RADIUS: radius_q = val[2:0];
      REG_WIDTH:  width_q = val[8:0];
      default:    height_q = val[8:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_rad();
    return ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 2000000);
  endfunction

  task automatic run_phase(logic [31:0] gray, logic [2:0] rad, logic [8:0] w,
                           logic [8:0] h, int n);
    int ew, eh, pick;
    logic [7:0] x, y;
    write_reg(REG_GRAY, gray);
    write_reg(REG_RADIUS, 32'(rad));
    write_reg(REG_WIDTH, 32'(w));
    write_reg(REG_HEIGHT, 32'(h));
    ew = eff_dim(w);
    eh = eff_dim(h);
    for (int j = 0; j < eh; j++)
      for (int i = 0; i < ew; i++)
        if (!px_valid[j * STORE_W + i])
          issue(KIND_SET, 8'(i), 8'(j), rand_rad(), rand_rad(), rand_rad());
    for (int k = 0; k < n; k++) begin
      gaps = (n_items < QUIET_FROM);
      pick = $urandom_range(0, 19);
      if ($urandom_range(0, 9) < 7) begin
        x = 8'($urandom_range(0, ew - 1));
        y = 8'($urandom_range(0, eh - 1));
      end else begin
        x = 8'($urandom);
        y = 8'($urandom);
      end
      if (pick < 6)
        issue(KIND_SET, x, y, rand_rad(), rand_rad(), rand_rad());
      else if (pick < 13)
        issue(KIND_ADD, x, y, rand_rad(), rand_rad(), rand_rad());
      else if (pick < 19)
        issue(KIND_READ, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
      else
        issue(KIND_NONE, x, y, $urandom, $urandom, $urandom);
    end
  endtask

  row_t plan[] = '{
    '{1'b0, KIND_SET, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{1'b0, KIND_READ, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{1'b0, KIND_SET, 8'd255, 8'd255, '1, '1, '1, 1'b0, '0},
    '{1'b0, KIND_READ, 8'd255, 8'd255, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{1'b0, KIND_ADD, 8'd255, 8'd255, 32'd1, 32'h8000_0000, 32'd0, 1'b0, '0},
    '{1'b0, KIND_READ, 8'd255, 8'd255, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{1'b0, KIND_ADD, 8'd10, 8'd10, 32'h10000, 32'd0, '1, 1'b0, '0},
    '{1'b0, KIND_READ, 8'd10, 8'd10, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{1'b0, KIND_NONE, 8'd1, 8'd1, '1, '1, '1, 1'b0, '0},
    '{1'b0, KIND_SET, 8'd3, 8'd4, 32'd655360, 32'd0, 32'd0, 1'b0, '0},
    '{1'b0, KIND_READ, 8'd3, 8'd4, 32'd0, 32'd0, 32'd0, 1'b1, '{8'd127, 8'd0, 8'd0}},
    '{1'b1, REG_GRAY, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{1'b0, KIND_READ, 8'd3, 8'd4, 32'd0, 32'd0, 32'd0, 1'b1, '{8'd255, 8'd0, 8'd0}},
    '{1'b0, KIND_READ, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{1'b1, REG_GRAY, 8'd0, 8'd0, '1, 32'd0, 32'd0, 1'b0, '0},
    '{1'b0, KIND_READ, 8'd255, 8'd255, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{1'b1, REG_GRAY, 8'd0, 8'd0, 32'd1, 32'd0, 32'd0, 1'b0, '0},
    '{1'b0, KIND_READ, 8'd10, 8'd10, 32'd0, 32'd0, 32'd0, 1'b0, '0}
  };

  initial begin
    start <= 1'b0;
    kind <= KIND_SET;
    pos_x <= '0;
    pos_y <= '0;
    radiance_red <= '0;
    radiance_green <= '0;
    radiance_blue <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_GRAY;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].code, plan[i].rr);
      end else begin
        ovr_on = plan[i].typed;
        ovr_col = plan[i].col;
        issue(plan[i].code, plan[i].x, plan[i].y, plan[i].rr, plan[i].rg, plan[i].rb);
        ovr_on = 1'b0;
      end
    end
    run_phase(32'd655360, 3'd7, 9'd16, 9'd16, 8);
    run_phase(32'hFFFF_FFFF, 3'd3, 9'd511, 9'd1, 20);
    run_phase(32'd0, 3'd2, 9'd1, 9'd300, 20);
    run_phase(32'd1, 3'd5, 9'd0, 9'd0, 20);
    run_phase($urandom, 3'd7, 9'd5, 9'd4, 20);
    while (n_items < ITEMS)
      run_phase($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 4000000),
                3'($urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 2)),
                9'($urandom_range(1, 6)), 9'($urandom_range(1, 6)), 50);
    settle();
    repeat (200) @(posedge clk);
    if (errors == 0 && colour_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
